// ===== hw/rtl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial line framer and classifier package
// Shared widths, codes, characters and structures of the line framer.
// ----------------------------------------------------------------------------
package slc_pkg;

   localparam int BYTE_W  = 8;
   localparam int EV_W    = 3;
   localparam int LEN_W   = 9;
   localparam int ID_W    = 64;
   localparam int IDLEN_W = 4;
   localparam int TMO_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam int MAX_LINE_DEFAULT = 256;

   localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd1000;
   localparam logic [IDLEN_W-1:0] ID_LEN_MAX    = 4'd8;

   // Register indexes of the configuration channel.
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ID     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ID_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MS    = 2'd2;

   // Request operations.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result events.
   localparam logic [EV_W-1:0] EV_APPEND   = 3'd0;
   localparam logic [EV_W-1:0] EV_DATA     = 3'd1;
   localparam logic [EV_W-1:0] EV_LOG      = 3'd2;
   localparam logic [EV_W-1:0] EV_OVERFLOW = 3'd3;
   localparam logic [EV_W-1:0] EV_TIMEOUT  = 3'd4;

   // Checksum tag phases.
   localparam logic [1:0] TAG_NONE   = 2'd0;
   localparam logic [1:0] TAG_DIGITS = 2'd1;
   localparam logic [1:0] TAG_CLOSED = 2'd2;
   localparam logic [1:0] TAG_BAD    = 2'd3;

   // Characters.
   localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h3C; // '<'
   localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h3E; // '>'
   localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B; // ';'
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A; // ':'
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [3*BYTE_W-1:0] CKS_TRIPLE = 24'h434B53; // "CKS"

   typedef struct packed {
      logic [ID_W-1:0]    device_id;
      logic [IDLEN_W-1:0] device_id_length;
      logic [TMO_W-1:0]   timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic                  prefix_failed;
      logic [3*BYTE_W-1:0]   recent_bytes;
      logic [1:0]            checksum_phase;
   } match_state_type;

endpackage

// ===== hw/rtl/slc_if.sv =====
// ----------------------------------------------------------------------------
// Serial line framer channel interfaces
// Request, response and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
interface slc_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [slc_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output operation, output rx_byte, input ready);
   modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface slc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [slc_pkg::BYTE_W-1:0] echo_byte;
   logic [slc_pkg::EV_W-1:0]   event_res;
   logic [slc_pkg::LEN_W-1:0]  line_length;

   modport source (output valid, output echo_byte, output event_res,
                   output line_length, input ready);
   modport sink   (input valid, input echo_byte, input event_res,
                   input line_length, output ready);
endinterface

interface slc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [slc_pkg::CSR_IDX_W-1:0] index;
   logic [slc_pkg::ID_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/slc_line_matcher.sv =====
// ----------------------------------------------------------------------------
// Line matcher
// Matches one received byte against the start pattern and the checksum tag
// and decides the event and the next line state.
// ----------------------------------------------------------------------------
module slc_line_matcher #(
   parameter int MAX_LINE = slc_pkg::MAX_LINE_DEFAULT,
   parameter int CNT_W    = $clog2(MAX_LINE)
) (
   input  slc_pkg::cfg_type                cfg,
   input  slc_pkg::match_state_type        st_cur,
   input  logic [CNT_W-1:0]                count_cur,
   input  logic [slc_pkg::TMO_W-1:0]       ms_since,
   input  logic [slc_pkg::BYTE_W-1:0]      rx_byte,
   output slc_pkg::match_state_type        st_next,
   output logic [CNT_W-1:0]                count_next,
   output logic [slc_pkg::EV_W-1:0]        event_res,
   output logic [slc_pkg::LEN_W-1:0]       line_length,
   output logic                            timer_restart
);
   import slc_pkg::*;

   localparam int CMP_W = (CNT_W + 1 > 5) ? CNT_W + 1 : 5;

   logic [IDLEN_W-1:0]  id_len;
   logic [CMP_W-1:0]    id_len_ext;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    pos_m1;
   logic [2:0]          id_sel;
   logic [BYTE_W-1:0]   want;
   logic [CNT_W:0]      count_inc;
   logic                is_digit;
   logic                data_line;
   match_state_type     st_match;

   assign id_len     = (cfg.device_id_length > ID_LEN_MAX) ? ID_LEN_MAX
                                                           : cfg.device_id_length;
   assign id_len_ext = CMP_W'(id_len);
   assign pos_ext    = CMP_W'(count_cur);
   assign pos_m1     = pos_ext - CMP_W'(1);
   assign id_sel     = pos_m1[2:0];
   assign count_inc  = {1'b0, count_cur} + (CNT_W+1)'(1);
   assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

   always_comb begin
      if (pos_ext == '0) begin
         want = CH_OPEN;
      end else if (pos_ext == id_len_ext + CMP_W'(1)) begin
         want = CH_SEMI;
      end else begin
         want = cfg.device_id[{id_sel, 3'b000} +: BYTE_W];
      end
   end

   always_comb begin
      st_match = st_cur;
      if ((pos_ext <= id_len_ext + CMP_W'(1)) && (rx_byte != want)) begin
         st_match.prefix_failed = 1'b1;
      end
      if ((rx_byte == CH_COLON) && (st_cur.recent_bytes == CKS_TRIPLE)) begin
         st_match.checksum_phase = TAG_DIGITS;
      end else if (st_cur.checksum_phase == TAG_DIGITS) begin
         if (rx_byte == CH_CLOSE) begin
            st_match.checksum_phase = TAG_CLOSED;
         end else if (!is_digit) begin
            st_match.checksum_phase = TAG_BAD;
         end
      end
      st_match.recent_bytes = {st_cur.recent_bytes[2*BYTE_W-1:0], rx_byte};
   end

   assign data_line = !st_match.prefix_failed
                      && (CMP_W'(count_inc) >= id_len_ext + CMP_W'(2))
                      && (st_match.checksum_phase == TAG_CLOSED);

   assign line_length = LEN_W'(count_inc);

   // Every outcome except a plain append closes the line and clears its state.
   always_comb begin
      st_next       = '0;
      count_next    = '0;
      timer_restart = 1'b0;
      priority if (count_inc >= (CNT_W+1)'(MAX_LINE)) begin
         event_res = EV_OVERFLOW;
      end else if ((rx_byte == CH_LF) || (rx_byte == CH_CR)) begin
         event_res     = data_line ? EV_DATA : EV_LOG;
         timer_restart = 1'b1;
      end else if (ms_since > cfg.timeout_ms) begin
         event_res     = EV_TIMEOUT;
         timer_restart = 1'b1;
      end else begin
         event_res  = EV_APPEND;
         st_next    = st_match;
         count_next = count_inc[CNT_W-1:0];
      end
   end

endmodule

// ===== hw/rtl/serial_line_framer_classifier_core.sv =====
// ----------------------------------------------------------------------------
// Serial line framer and classifier core
// Frames received bytes into lines and classes each line ended by CR or LF as data or log.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries either a received byte or a one millisecond
//   tick. Every byte request gives exactly one response with the byte, its
//   event and the line length including the byte; a tick gives none.
//   A request is accepted in every cycle while the response register is
//   empty or being drained, so the block sustains one request per cycle.
//   The response is registered and appears in the cycle after the byte is
//   accepted; the line state is updated together with the response register.
//   When the receiver stalls, the response register holds its value and the
//   request channel stalls with it; ticks are held off as well.
//   The configuration channel is always ready and writes the device id, the
//   id length and the timeout; a write to an unused index has no effect.
//   Synchronous reset clears the open line, the millisecond counter and the
//   response register, and loads the register defaults (timeout 1000 ms).
// ----------------------------------------------------------------------------
module serial_line_framer_classifier_core #(
   parameter int MAX_LINE = slc_pkg::MAX_LINE_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   slc_req_if.sink   req_chan,
   slc_rsp_if.source rsp_chan,
   slc_csr_if.sink   csr_chan
);
   import slc_pkg::*;

   localparam int CNT_W = $clog2(MAX_LINE);

   cfg_type               cfg_ff, cfg_in;
   match_state_type       st_ff, st_in, st_next;
   logic [CNT_W-1:0]      count_ff, count_in, count_next;
   logic [TMO_W-1:0]      ms_ff, ms_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     echo_ff;
   logic [EV_W-1:0]       event_ff, event_next;
   logic [LEN_W-1:0]      len_ff, len_next;
   logic                  timer_restart;
   logic                  req_fire;
   logic                  byte_fire;
   logic                  tick_fire;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign byte_fire = req_fire && (req_chan.operation == OP_BYTE);
   assign tick_fire = req_fire && (req_chan.operation == OP_TICK);

   assign csr_chan.ready = 1'b1;

   slc_line_matcher #(
      .MAX_LINE (MAX_LINE),
      .CNT_W    (CNT_W)
   ) u_matcher (
      .cfg           (cfg_ff),
      .st_cur        (st_ff),
      .count_cur     (count_ff),
      .ms_since      (ms_ff),
      .rx_byte       (req_chan.rx_byte),
      .st_next       (st_next),
      .count_next    (count_next),
      .event_res     (event_next),
      .line_length   (len_next),
      .timer_restart (timer_restart)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DEVICE_ID:     cfg_in.device_id        = csr_chan.data;
            CSR_DEVICE_ID_LEN: cfg_in.device_id_length = csr_chan.data[IDLEN_W-1:0];
            CSR_TIMEOUT_MS:    cfg_in.timeout_ms       = csr_chan.data[TMO_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      st_in    = st_ff;
      count_in = count_ff;
      ms_in    = ms_ff;
      if (byte_fire) begin
         st_in    = st_next;
         count_in = count_next;
         if (timer_restart) begin
            ms_in = '0;
         end
      end else if (tick_fire && (ms_ff != '1)) begin
         ms_in = ms_ff + TMO_W'(1);
      end
   end

   always_comb begin
      if (byte_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_id        <= '0;
         cfg_ff.device_id_length <= '0;
         cfg_ff.timeout_ms       <= TIMEOUT_RESET;
         st_ff                   <= '0;
         count_ff                <= '0;
         ms_ff                   <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         st_ff        <= st_in;
         count_ff     <= count_in;
         ms_ff        <= ms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_fire) begin
         echo_ff  <= req_chan.rx_byte;
         event_ff <= event_next;
         len_ff   <= len_next;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.echo_byte   = echo_ff;
   assign rsp_chan.event_res   = event_ff;
   assign rsp_chan.line_length = len_ff;

`ifndef ASSERT_OFF
   // The open line never reaches the maximum length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (CNT_W+1)'(count_ff) < (CNT_W+1)'(MAX_LINE))
      else $error("line byte count reached the maximum length");

   // A byte that closes or discards the line leaves an empty line behind.
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (byte_fire && (event_next != EV_APPEND)) |=> (count_ff == '0))
      else $error("line state not cleared after line end or discard");

   // A tick leaves the line untouched and produces no response.
   a_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      (tick_fire && !rsp_valid_ff) |=> ($stable(count_ff) && !rsp_valid_ff))
      else $error("tick changed the line or produced a response");

   // An appended byte grows the line by one.
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (byte_fire && (event_next == EV_APPEND)) |=>
         (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("appended byte did not advance the line count");
`endif

endmodule
